### rtl/bcmc_pkg.sv
// Shared types and constants for the button click menu controller.
// Holds the tick and result payload structs, mode and click codes and register indexes.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package bcmc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_DOUBLE_CLICK = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [2:0] REG_VALUE_MIN    = 3'd3;
  localparam logic [2:0] REG_VALUE_MAX    = 3'd4;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned COUNT_BITS     = 16;
  localparam int unsigned VALUE_BITS     = 8;

  // Power-on register values.
  localparam logic [COUNT_BITS-1:0] DEBOUNCE_RESET     = 16'd30;
  localparam logic [COUNT_BITS-1:0] DOUBLE_CLICK_RESET = 16'd350;
  localparam logic [COUNT_BITS-1:0] LONG_PRESS_RESET   = 16'd800;
  localparam logic [VALUE_BITS-1:0] VALUE_MIN_RESET    = 8'd0;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX_RESET    = 8'd99;

  // The heartbeat follows bit 9 of the tick time (a period of 1024 ticks).
  localparam int unsigned HEARTBEAT_BIT = 9;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_INFO   = 2'd1,
    MODE_CONFIG = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2,
    CLICK_LONG   = 2'd3
  } click_t;

  typedef struct packed {
    logic menu_level;
    logic up_level;
    logic down_level;
  } tick_t;

  typedef struct packed {
    logic [1:0]            menu_state;
    logic [VALUE_BITS-1:0] setting_value;
    logic [1:0]            click_event;
    logic                  value_changed;
    logic                  heartbeat_led;
  } result_t;

endpackage

### rtl/bcmc_press_debounce.sv
// Press debouncer for one adjustment button (active low).
// Confirms a falling edge once the level has held for the debounce interval.
// Depends on bcmc_pkg for the counter width.
`timescale 1ns / 1ps

module bcmc_press_debounce (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            level,
  input  logic                            detect,
  input  logic [bcmc_pkg::COUNT_BITS-1:0] debounce_ticks,
  output logic                            hit
);
  import bcmc_pkg::*;

  logic                  prev;
  logic                  prev_next;
  logic [COUNT_BITS-1:0] left;
  logic [COUNT_BITS-1:0] left_next;

  always_comb begin
    hit       = 1'b0;
    left_next = left;
    prev_next = prev;
    if (left != '0) begin
      left_next = left - 1'b1;
      hit       = (left == COUNT_BITS'(1)) && !level;
    end else if (detect && prev && !level) begin
      if (debounce_ticks == '0) begin
        hit = 1'b1;
      end else begin
        left_next = debounce_ticks;
      end
    end
    // The previous level only tracks the pin while detection is enabled.
    if (detect) begin
      prev_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 1'b1;
      left <= '0;
    end else if (step) begin
      prev <= prev_next;
      left <= left_next;
    end
  end

endmodule

### rtl/button_click_menu_controller.sv
// Top level of the button click menu controller: menu click classifier and setting control.
// Instantiates bcmc_press_debounce for the up and down buttons; uses bcmc_pkg.
//
//   Port group   Direction  Carries
//   tick         in         one millisecond tick: three sampled active-low button levels
//   result       out        mode, setting, click event, change flag and heartbeat per tick
//   cfg          in         register writes: debounce, window, long press, min, max
//
// Each tick is handled in the cycle it is transferred; its result appears in the
// result register on the next cycle, so one tick per clock is sustained while not stalled.
// The only storage between ticks is the state registers and that single result register.
// A tick is taken whenever the result register is empty or being transferred out.
// Synchronous reset clears all state but result data and restores the register defaults.
`timescale 1ns / 1ps

module button_click_menu_controller #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  bcmc_pkg::tick_t                     tick,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bcmc_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [bcmc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bcmc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import bcmc_pkg::*;

  // Configuration registers.
  logic [COUNT_BITS-1:0] debounce_ticks;
  logic [COUNT_BITS-1:0] double_click_window;
  logic [COUNT_BITS-1:0] long_press_ticks;
  logic [VALUE_BITS-1:0] value_minimum;
  logic [VALUE_BITS-1:0] value_maximum;

  // Tick state.
  logic [TIME_BITS-1:0]  tick_count;
  logic                  menu_prev;
  logic [COUNT_BITS-1:0] menu_left;
  logic [COUNT_BITS-1:0] menu_left_next;
  logic                  menu_kind;
  logic                  menu_kind_next;
  logic [TIME_BITS-1:0]  press_time;
  logic [TIME_BITS-1:0]  press_time_next;
  logic [TIME_BITS-1:0]  release_time;
  logic [TIME_BITS-1:0]  release_time_next;
  logic                  click_pending;
  logic                  click_pending_next;
  mode_t                 mode;
  mode_t                 mode_next;
  logic [VALUE_BITS-1:0] setting;
  logic [VALUE_BITS-1:0] setting_next;
  logic [VALUE_BITS-1:0] setting_up;

  logic                  accept;
  logic                  confirmed;
  logic                  confirmed_kind;
  logic [TIME_BITS-1:0]  held;
  logic [TIME_BITS-1:0]  gap;
  logic [TIME_BITS-1:0]  since_release;
  logic                  in_config;
  logic                  up_hit;
  logic                  down_hit;
  logic                  up_step;
  logic                  down_step;
  click_t                click;
  result_t               result_next;

  assign tick_stall = result_valid && result_stall;
  assign accept     = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= DEBOUNCE_RESET;
      double_click_window <= DOUBLE_CLICK_RESET;
      long_press_ticks    <= LONG_PRESS_RESET;
      value_minimum       <= VALUE_MIN_RESET;
      value_maximum       <= VALUE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:     debounce_ticks      <= cfg_data;
        REG_DOUBLE_CLICK: double_click_window <= cfg_data;
        REG_LONG_PRESS:   long_press_ticks    <= cfg_data;
        REG_VALUE_MIN:    value_minimum       <= cfg_data[VALUE_BITS-1:0];
        REG_VALUE_MAX:    value_maximum       <= cfg_data[VALUE_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Menu button debounce; a confirmed kind of 0 is a press, 1 a release.
  always_comb begin
    confirmed      = 1'b0;
    confirmed_kind = 1'b0;
    menu_left_next = menu_left;
    menu_kind_next = menu_kind;
    if (menu_left != '0) begin
      menu_left_next = menu_left - 1'b1;
      confirmed      = (menu_left == COUNT_BITS'(1)) && (tick.menu_level == menu_kind);
      confirmed_kind = menu_kind;
    end else if (tick.menu_level != menu_prev) begin
      if (debounce_ticks == '0) begin
        confirmed      = 1'b1;
        confirmed_kind = tick.menu_level;
      end else begin
        menu_left_next = debounce_ticks;
        menu_kind_next = tick.menu_level;
      end
    end
  end

  assign held          = tick_count - press_time;
  assign gap           = press_time - release_time;
  assign since_release = tick_count - release_time;

  // Click classification. Expiry is tested after press and release handling. A confirmed
  // release either clears the pending click or restamps it to now, so it never expires on
  // that tick; a confirmed press leaves the pending click free to expire.
  always_comb begin
    press_time_next    = press_time;
    release_time_next  = release_time;
    click_pending_next = click_pending;
    mode_next          = mode;
    click              = CLICK_NONE;
    if (confirmed && !confirmed_kind) begin
      press_time_next = tick_count;
    end else if (confirmed) begin
      if (held >= TIME_BITS'(long_press_ticks)) begin
        mode_next          = MODE_CONFIG;
        click_pending_next = 1'b0;
        click              = CLICK_LONG;
      end else if (click_pending && (gap < TIME_BITS'(double_click_window))) begin
        mode_next          = MODE_INFO;
        click_pending_next = 1'b0;
        click              = CLICK_DOUBLE;
      end else begin
        click_pending_next = 1'b1;
        release_time_next  = tick_count;
      end
    end
    if (click_pending_next && !(confirmed && confirmed_kind) &&
        (since_release > TIME_BITS'(double_click_window))) begin
      mode_next          = MODE_START;
      click_pending_next = 1'b0;
      click              = CLICK_SINGLE;
    end
  end

  assign in_config = (mode_next == MODE_CONFIG);

  bcmc_press_debounce u_up (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .level          (tick.up_level),
    .detect         (in_config),
    .debounce_ticks (debounce_ticks),
    .hit            (up_hit)
  );

  bcmc_press_debounce u_down (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .level          (tick.down_level),
    .detect         (in_config),
    .debounce_ticks (debounce_ticks),
    .hit            (down_hit)
  );

  // Up is applied before down, so down compares against the stepped value.
  assign up_step      = up_hit && in_config && (setting < value_maximum);
  assign setting_up   = up_step ? setting + 1'b1 : setting;
  assign down_step    = down_hit && in_config && (setting_up > value_minimum);
  assign setting_next = down_step ? setting_up - 1'b1 : setting_up;

  always_comb begin
    result_next.menu_state    = mode_next;
    result_next.setting_value = setting_next;
    result_next.click_event   = click;
    result_next.value_changed = up_step || down_step;
    result_next.heartbeat_led = !tick_count[HEARTBEAT_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      menu_prev     <= 1'b1;
      menu_left     <= '0;
      menu_kind     <= 1'b0;
      press_time    <= '0;
      release_time  <= '0;
      click_pending <= 1'b0;
      mode          <= MODE_START;
      setting       <= '0;
    end else if (accept) begin
      tick_count    <= tick_count + 1'b1;
      menu_prev     <= tick.menu_level;
      menu_left     <= menu_left_next;
      menu_kind     <= menu_kind_next;
      press_time    <= press_time_next;
      release_time  <= release_time_next;
      click_pending <= click_pending_next;
      mode          <= mode_next;
      setting       <= setting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // A setting change is only reported in config mode.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.value_changed |-> result.menu_state == MODE_CONFIG)
    else $error("setting changed outside config mode");

  // Every click event reports the mode it selects.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.click_event == CLICK_NONE) ||
      (result.click_event == CLICK_SINGLE && result.menu_state == MODE_START) ||
      (result.click_event == CLICK_DOUBLE && result.menu_state == MODE_INFO) ||
      (result.click_event == CLICK_LONG && result.menu_state == MODE_CONFIG))
    else $error("click event does not match the selected mode");

  // A transferred tick always leaves a result waiting on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> result_valid)
    else $error("accepted tick produced no result");

endmodule

### dv/tb_button_click_menu_controller.sv
// Self-checking testbench for the button click menu controller.
// Drives button ticks and register writes, predicts every readout and checks it on transfer.
// Depends on bcmc_pkg and button_click_menu_controller from rtl.
`timescale 1ns / 1ps

module tb_button_click_menu_controller;
  import bcmc_pkg::*;

  localparam int SCRIPT_ROWS     = 26;
  localparam int HOLD_OFF_CYCLES = 64;

  localparam tick_t ALL_UP     = 3'b111;
  localparam tick_t MENU_DOWN  = 3'b011;
  localparam tick_t UP_PRESS   = 3'b101;
  localparam tick_t DOWN_PRESS = 3'b110;
  localparam tick_t BOTH_KEYS  = 3'b100;

  localparam result_t NO_RESULT     = '0;
  localparam result_t IDLE_RESULT   = {MODE_START, 8'd0, CLICK_NONE, 1'b0, 1'b1};
  localparam result_t DOUBLE_RESULT = {MODE_INFO, 8'd0, CLICK_DOUBLE, 1'b0, 1'b1};
  localparam result_t LONG_RESULT   = {MODE_CONFIG, 8'd0, CLICK_LONG, 1'b0, 1'b1};

  typedef struct packed {
    tick_t   levels;
    logic    fixed;
    result_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  tick_t tick = ALL_UP;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  button_click_menu_controller u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Settings as the block should hold them.
  logic [15:0] debounce_cfg = DEBOUNCE_RESET;
  logic [15:0] window_cfg   = DOUBLE_CLICK_RESET;
  logic [15:0] long_cfg     = LONG_PRESS_RESET;
  logic [7:0]  min_cfg      = VALUE_MIN_RESET;
  logic [7:0]  max_cfg      = VALUE_MAX_RESET;

  // Predicted internal state of the block.
  logic [31:0] clock_ms   = '0;
  logic [31:0] press_at   = '0;
  logic [31:0] release_at = '0;
  logic        menu_last  = 1'b1;
  logic        up_last    = 1'b1;
  logic        down_last  = 1'b1;
  logic [15:0] menu_wait  = '0;
  logic [15:0] up_wait    = '0;
  logic [15:0] down_wait  = '0;
  logic        menu_target = 1'b0;
  logic        click_waiting = 1'b0;
  mode_t       cur_mode = MODE_START;
  logic [7:0]  level_setting = '0;

  result_t expected_readouts[$];
  result_t readout_due;
  script_row_t script [SCRIPT_ROWS];

  int   mismatches = 0;
  int   quota_left = 0;
  int   feed_idle_pct = 0;
  int   drain_idle_pct = 0;
  int   tick_gap = 0;
  logic tick_up = 1'b0;
  logic hold_off_req = 1'b0;

  task automatic debounce_key(input logic lvl, input logic live, inout logic last,
                              inout logic [15:0] left, output logic hit);
    hit = 1'b0;
    if (left != 0) begin
      left = left - 1'b1;
      if (left == 0 && lvl == 1'b0) begin
        hit = 1'b1;
      end
    end else if (live && last && !lvl) begin
      if (debounce_cfg == 0) begin
        hit = 1'b1;
      end else begin
        left = debounce_cfg;
      end
    end
    if (live) begin
      last = lvl;
    end
  endtask

  // Works out the readout for one tick and advances the predicted state.
  task automatic classify_tick(input tick_t lv, output result_t r);
    logic [31:0] now;
    logic [31:0] held;
    logic [31:0] gap;
    logic        confirmed;
    logic        kind;
    logic        in_config;
    logic        up_hit;
    logic        down_hit;
    logic        changed;
    click_t      ev;
    now = clock_ms;
    confirmed = 1'b0;
    kind = 1'b0;
    changed = 1'b0;
    ev = CLICK_NONE;

    if (menu_wait != 0) begin
      menu_wait = menu_wait - 1'b1;
      if (menu_wait == 0 && lv.menu_level == menu_target) begin
        confirmed = 1'b1;
        kind = menu_target;
      end
    end else if (lv.menu_level != menu_last) begin
      if (debounce_cfg == 0) begin
        confirmed = 1'b1;
        kind = lv.menu_level;
      end else begin
        menu_wait = debounce_cfg;
        menu_target = lv.menu_level;
      end
    end
    menu_last = lv.menu_level;

    if (confirmed && !kind) begin
      press_at = now;
    end else if (confirmed) begin
      held = now - press_at;
      gap = press_at - release_at;
      if (held >= long_cfg) begin
        cur_mode = MODE_CONFIG;
        click_waiting = 1'b0;
        ev = CLICK_LONG;
      end else if (click_waiting && gap < window_cfg) begin
        cur_mode = MODE_INFO;
        click_waiting = 1'b0;
        ev = CLICK_DOUBLE;
      end else begin
        click_waiting = 1'b1;
        release_at = now;
      end
    end

    // Expiry is looked at after the release, so it can override nothing on the same tick.
    if (click_waiting && (now - release_at) > window_cfg) begin
      cur_mode = MODE_START;
      click_waiting = 1'b0;
      ev = CLICK_SINGLE;
    end

    in_config = (cur_mode == MODE_CONFIG);
    debounce_key(lv.up_level, in_config, up_last, up_wait, up_hit);
    if (up_hit && in_config && level_setting < max_cfg) begin
      level_setting = level_setting + 1'b1;
      changed = 1'b1;
    end
    debounce_key(lv.down_level, in_config, down_last, down_wait, down_hit);
    if (down_hit && in_config && level_setting > min_cfg) begin
      level_setting = level_setting - 1'b1;
      changed = 1'b1;
    end

    r.menu_state    = cur_mode;
    r.setting_value = level_setting;
    r.click_event   = ev;
    r.value_changed = changed;
    r.heartbeat_led = ~now[HEARTBEAT_BIT];
    clock_ms = clock_ms + 1'b1;
  endtask

  // Offers one tick and returns at the edge where it is transferred.
  task automatic send_tick(input tick_t lv, input logic fixed, input result_t typed);
    result_t predicted;
    if (!tick_up) begin
      repeat (tick_gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= lv;
    @(negedge clk);
    while (tick_stall) @(negedge clk);
    @(posedge clk);
    classify_tick(lv, predicted);
    expected_readouts.push_back(fixed ? typed : predicted);
    if ($urandom_range(0, 99) < feed_idle_pct) begin
      tick_gap = $urandom_range(1, 16);
      tick_valid <= 1'b0;
      tick_up = 1'b0;
    end else begin
      tick_up = 1'b1;
    end
  endtask

  task automatic hold(input tick_t lv, input int n);
    repeat (n) begin
      if (quota_left > 0) begin
        send_tick(lv, 1'b0, NO_RESULT);
        quota_left--;
      end
    end
  endtask

  task automatic settle();
    if (tick_up) begin
      tick_valid <= 1'b0;
      tick_up = 1'b0;
    end
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic retune(input logic [15:0] deb, input logic [15:0] win,
                        input logic [15:0] lng, input logic [7:0] lo, input logic [7:0] hi);
    settle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DOUBLE_CLICK, win);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_VALUE_MIN, {8'd0, lo});
    write_reg(REG_VALUE_MAX, {8'd0, hi});
    cfg_we <= 1'b0;
    debounce_cfg = deb;
    window_cfg = win;
    long_cfg = lng;
    min_cfg = lo;
    max_cfg = hi;
  endtask

  function automatic int capped(input int x, input int lim);
    return (x > lim) ? lim : x;
  endfunction

  // Mostly well-formed button gestures timed around the current settings, with some chatter.
  task automatic run_phase(input int items, input int send_pct, input int stall_pct);
    int   deb_span;
    int   long_span;
    int   win_span;
    int   short_hold;
    int   press_len;
    int   gap_len;
    logic u;
    logic d;
    feed_idle_pct = send_pct;
    drain_idle_pct = stall_pct;
    quota_left = items;
    deb_span = capped(debounce_cfg, 40);
    long_span = capped(long_cfg, 900);
    win_span = capped(window_cfg, 900);
    while (quota_left > 0) begin
      short_hold = deb_span + 1 + $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) hold(tick_t'($urandom_range(0, 7)), 1);
          end
          press_len = ($urandom_range(0, 3) == 0) ?
                      deb_span + long_span - 1 + $urandom_range(0, 2) : short_hold;
          if (press_len < 1) begin
            press_len = 1;
          end
          hold(MENU_DOWN, press_len);
          case ($urandom_range(0, 2))
            0: gap_len = short_hold;
            1: gap_len = win_span + $urandom_range(0, 3);
            default: gap_len = deb_span + win_span + 2 + $urandom_range(0, 2);
          endcase
          hold(ALL_UP, gap_len);
        end
        4, 5: begin
          u = $urandom_range(0, 1);
          d = u ? 1'b0 : 1'(($urandom_range(0, 1)));
          hold({1'b1, u, d}, short_hold);
          hold(ALL_UP, short_hold);
        end
        6: begin
          repeat ($urandom_range(1, 12)) hold(tick_t'($urandom_range(0, 7)), 1);
        end
        7: begin
          hold(MENU_DOWN, deb_span + long_span + 2);
          hold(ALL_UP, deb_span + 2);
        end
        8: begin
          u = $urandom_range(0, 1);
          repeat ($urandom_range(3, 12)) begin
            hold(u ? DOWN_PRESS : UP_PRESS, deb_span + 1);
            hold(ALL_UP, deb_span + 1);
          end
        end
        default: hold(ALL_UP, $urandom_range(1, deb_span + 4));
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Outputs are settled by the falling edge; a readout seen here is transferred at the next rise.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_readouts.size() == 0) begin
        mismatches++;
        $display("%0t: readout with none expected, expected nothing, got %h", $time, result);
      end else begin
        readout_due = expected_readouts.pop_front();
        check_field("menu_state", readout_due.menu_state, result.menu_state);
        check_field("setting_value", readout_due.setting_value, result.setting_value);
        check_field("click_event", readout_due.click_event, result.click_event);
        check_field("value_changed", readout_due.value_changed, result.value_changed);
        check_field("heartbeat_led", readout_due.heartbeat_led, result.heartbeat_led);
      end
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if ($urandom_range(0, 99) < drain_idle_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    // Each row's index is also its tick time; debounce is switched off from row two onwards.
    script[0]  = {ALL_UP, 1'b1, IDLE_RESULT};
    script[1]  = {BOTH_KEYS, 1'b1, IDLE_RESULT};
    script[2]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[3]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[4]  = {ALL_UP, 1'b0, NO_RESULT};
    script[5]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[6]  = {ALL_UP, 1'b1, DOUBLE_RESULT};
    script[7]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[8]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[9]  = {MENU_DOWN, 1'b0, NO_RESULT};
    script[10] = {MENU_DOWN, 1'b0, NO_RESULT};
    script[11] = {MENU_DOWN, 1'b0, NO_RESULT};
    script[12] = {ALL_UP, 1'b1, LONG_RESULT};
    script[13] = {UP_PRESS, 1'b0, NO_RESULT};
    script[14] = {UP_PRESS, 1'b0, NO_RESULT};
    script[15] = {DOWN_PRESS, 1'b0, NO_RESULT};
    script[16] = {UP_PRESS, 1'b0, NO_RESULT};
    script[17] = {ALL_UP, 1'b0, NO_RESULT};
    script[18] = {BOTH_KEYS, 1'b0, NO_RESULT};
    script[19] = {ALL_UP, 1'b0, NO_RESULT};
    script[20] = {MENU_DOWN, 1'b0, NO_RESULT};
    script[21] = {ALL_UP, 1'b0, NO_RESULT};
    script[22] = {ALL_UP, 1'b0, NO_RESULT};
    script[23] = {ALL_UP, 1'b0, NO_RESULT};
    script[24] = {ALL_UP, 1'b0, NO_RESULT};
    script[25] = {BOTH_KEYS, 1'b0, NO_RESULT};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (i == 2) begin
        retune(16'd0, 16'd2, 16'd4, VALUE_MIN_RESET, VALUE_MAX_RESET);
      end
      send_tick(script[i].levels, script[i].fixed, script[i].want);
    end

    retune(DEBOUNCE_RESET, DOUBLE_CLICK_RESET, LONG_PRESS_RESET, VALUE_MIN_RESET,
           VALUE_MAX_RESET);
    run_phase(700, 5, 5);
    retune(16'd0, 16'd0, 16'd0, 8'd0, 8'd255);
    run_phase(250, 10, 2);
    retune(16'd1, 16'd8, 16'd12, 8'd5, 8'd20);
    hold_off_req = 1'b1;
    run_phase(700, 3, 3);
    retune(16'd3, 16'd20, 16'd40, 8'd3, 8'd7);
    run_phase(250, 15, 8);
    // Closing stretch runs at full rate on both sides.
    retune(16'd2, 16'd65535, 16'd10, 8'd200, 8'd10);
    run_phase(200, 0, 0);
    retune(16'd65535, 16'd0, 16'd0, 8'd255, 8'd0);
    run_phase(100, 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
